>>> hdl/ecc_error_log_and_patrol_scrub_core_defines.svh
// Assertion macros shared by the ECC error log and patrol scrub RTL.
`ifndef ECC_ERROR_LOG_AND_PATROL_SCRUB_CORE_DEFINES_SVH
`define ECC_ERROR_LOG_AND_PATROL_SCRUB_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ECCPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ECCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/eccps_pkg.sv
// Shared constants, command codes and types for the ECC log and scrub core.
`timescale 1ns / 1ps

package eccps_pkg;

  // Address handling: position and limit carry one extra bit so the end never wraps.
  localparam int ADDR_BITS = 48;
  localparam int POS_W     = ADDR_BITS + 1;
  localparam int EADDR_W   = 48;
  localparam int CNT_W     = 8;

  localparam int DEF_LOG_DEPTH = 16;

  localparam logic [31:0] DEFAULT_CHUNK = 32'd65536;

  // Command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Log entry kinds.
  localparam logic KIND_CE = 1'b0;
  localparam logic KIND_UE = 1'b1;

  // Request from the item stage to the log for one transfer.
  typedef struct packed {
    logic               wr0;
    logic               wr1;
    logic               kind0;
    logic [EADDR_W-1:0] addr;
    logic               rd;
    logic [3:0]         index;
  } log_req_t;

endpackage

>>> hdl/eccps_log.sv
// Ring log of error entries: two write banks, per-slot valid and bank select.
`timescale 1ns / 1ps
`include "ecc_error_log_and_patrol_scrub_core_defines.svh"

module eccps_log import eccps_pkg::*; #(
  parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  log_req_t           req,
  output logic [CNT_W-1:0]   head,
  output logic               rd_kind,
  output logic [EADDR_W-1:0] rd_addr
);

  localparam int SLOT_W = $clog2(LOG_DEPTH);
  localparam logic [7:0] DEPTH8 = 8'(LOG_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LOG_DEPTH - 1);

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] s1;
  logic [SLOT_W-1:0] s2;
  logic [SLOT_W-1:0] ridx;
  logic              we0;
  logic              we1;

  logic [LOG_DEPTH-1:0] vld;
  logic [LOG_DEPTH-1:0] sel;
  logic [LOG_DEPTH-1:0] vld_next;
  logic [LOG_DEPTH-1:0] sel_next;

  logic [EADDR_W:0] bank_a [LOG_DEPTH];
  logic [EADDR_W:0] bank_b [LOG_DEPTH];

  logic             rd_q;
  logic             rd_vld;
  logic             rd_sel;
  logic [EADDR_W:0] rd_a;
  logic [EADDR_W:0] rd_b;
  logic [EADDR_W:0] rd_word;

  // Slot after a write; the slot returns to zero after the last slot or when the count wraps.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0] c);
    if (c == {CNT_W{1'b1}} || s == LAST_SLOT) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // Read index reduced into the ring by repeated conditional subtraction.
  function automatic logic [SLOT_W-1:0] read_slot(input logic [3:0] idx);
    logic [7:0] v;
    v = {4'b0, idx};
    for (int i = 0; i < 8; i++) begin
      if (v >= DEPTH8) begin
        v = v - DEPTH8;
      end
    end
    return v[SLOT_W-1:0];
  endfunction

  assign s1   = slot_inc(slot, head);
  assign s2   = slot_inc(s1, head + 8'd1);
  assign ridx = read_slot(req.index);
  assign we0  = advance & req.wr0;
  assign we1  = advance & req.wr1;

  // Per-slot tracking bits after this transfer; the second entry wins when
  // both land on one slot.
  always_comb begin
    vld_next = vld;
    sel_next = sel;
    if (we0) begin
      vld_next[slot] = 1'b1;
      sel_next[slot] = 1'b0;
    end
    if (we1) begin
      vld_next[s1] = 1'b1;
      sel_next[s1] = 1'b1;
    end
  end

  // Head count, write slot, per-slot tracking bits and the registered read flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      slot   <= '0;
      vld    <= '0;
      sel    <= '0;
      rd_q   <= 1'b0;
      rd_vld <= 1'b0;
      rd_sel <= 1'b0;
    end else begin
      if (we1) begin
        head <= head + 8'd2;
        slot <= s2;
      end else if (we0) begin
        head <= head + 8'd1;
        slot <= s1;
      end
      vld <= vld_next;
      sel <= sel_next;
      if (advance) begin
        rd_q   <= req.rd;
        rd_vld <= vld[ridx];
        rd_sel <= sel[ridx];
      end
    end
  end

  // Entry storage, one write and one registered read per bank.
  always_ff @(posedge clk) begin
    if (we0) begin
      bank_a[slot] <= {req.kind0, req.addr};
    end
    if (we1) begin
      bank_b[s1] <= {KIND_UE, req.addr};
    end
    if (advance) begin
      rd_a <= bank_a[ridx];
      rd_b <= bank_b[ridx];
    end
  end

  // Unwritten slots read as zero, and items other than read show zero.
  assign rd_word = (rd_q && rd_vld) ? (rd_sel ? rd_b : rd_a) : '0;
  assign rd_kind = rd_word[EADDR_W];
  assign rd_addr = rd_word[EADDR_W-1:0];

  `ECCPS_ASSERT_NOW(a_slot_range, 1'b1, slot <= LAST_SLOT, "log slot out of range")
  `ECCPS_ASSERT_NOW(a_pair_order, req.wr1, req.wr0, "second entry without first")
  `ECCPS_ASSERT_NEXT(a_head_moves, we0, head != $past(head), "log write did not bump head")

endmodule

>>> hdl/ecc_error_log_and_patrol_scrub_core.sv
// Top level of the ECC error log and patrol scrub core.
`timescale 1ns / 1ps
`include "ecc_error_log_and_patrol_scrub_core_defines.svh"

// One result per item, one item per cycle while out_stall is low: each
// transfer lands in an input register, and when it advances all of its work
// (total compares, one scrub chunk subtract and compare, log bank write or
// read) runs into the result register.
// The log read comes from the registered read port of the log banks. Reset
// clears the per-slot valid bits at once, so no clearing pass is needed.

module ecc_error_log_and_patrol_scrub_core import eccps_pkg::*; #(
  parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [31:0]        ce_count,
  input  logic [31:0]        ue_count,
  input  logic [47:0]        err_addr,
  input  logic               status_ok,
  input  logic [47:0]        start_addr,
  input  logic [47:0]        scrub_size,
  input  logic [31:0]        chunk_len,
  input  logic [3:0]         log_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scrub_valid,
  output logic [48:0]        scrub_addr,
  output logic [31:0]        scrub_len,
  output logic               scrub_busy,
  output logic [31:0]        ce_total,
  output logic [31:0]        ue_total,
  output logic [7:0]         log_count,
  output logic [1:0]         logged_now,
  output logic               entry_kind,
  output logic [47:0]        entry_addr,
  output logic               start_rejected
);

  // Input register.
  logic        v1;
  logic [1:0]  q_cmd;
  logic [31:0] q_ce;
  logic [31:0] q_ue;
  logic [47:0] q_err_addr;
  logic        q_status_ok;
  logic [47:0] q_start;
  logic [47:0] q_size;
  logic [31:0] q_chunk;
  logic [3:0]  q_index;

  // Block state.
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] limit;
  logic [31:0]      chunk;
  logic             active;
  logic [31:0]      ce_tot;
  logic [31:0]      ue_tot;

  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] limit_next;
  logic [31:0]      chunk_next;
  logic             active_next;
  logic [31:0]      ce_tot_next;
  logic [31:0]      ue_tot_next;

  logic             advance;
  logic             is_tick;
  logic             is_start;
  logic             is_read;
  logic             ce_rise;
  logic             ue_rise;
  logic             can_issue;
  logic             last;
  logic [POS_W-1:0] left;
  logic [POS_W-1:0] chunk_w;
  logic [POS_W-1:0] len_w;
  logic [POS_W-1:0] new_limit;
  logic             size_zero;
  logic [1:0]       n_logged;
  logic [CNT_W-1:0] head;
  log_req_t         req;

  // The item stage moves whenever the result register is free or draining.
  assign advance  = v1 && (!out_valid || !out_stall);
  assign in_stall = v1 && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_cmd       <= cmd;
      q_ce        <= ce_count;
      q_ue        <= ue_count;
      q_err_addr  <= err_addr;
      q_status_ok <= status_ok;
      q_start     <= start_addr;
      q_size      <= scrub_size;
      q_chunk     <= chunk_len;
      q_index     <= log_index;
    end
  end

  // Command decode.
  always_comb begin
    is_tick  = 1'b0;
    is_start = 1'b0;
    is_read  = 1'b0;
    case (q_cmd)
      CMD_TICK:  is_tick  = 1'b1;
      CMD_START: is_start = 1'b1;
      CMD_READ:  is_read  = 1'b1;
      default:   ;
    endcase
  end

  // Error count rises and the log request.
  assign ce_rise = is_tick && q_status_ok && (q_ce > ce_tot);
  assign ue_rise = is_tick && q_status_ok && (q_ue > ue_tot);

  assign req.wr0   = ce_rise || ue_rise;
  assign req.wr1   = ce_rise && ue_rise;
  assign req.kind0 = ce_rise ? KIND_CE : KIND_UE;
  assign req.addr  = q_err_addr;
  assign req.rd    = is_read;
  assign req.index = q_index;

  assign n_logged = {1'b0, req.wr0} + {1'b0, req.wr1};

  // Scrub chunk: the last chunk is clipped to what is left of the region.
  assign can_issue = is_tick && active && (pos < limit);
  assign left      = limit - pos;
  assign chunk_w   = POS_W'(chunk);
  assign last      = chunk_w >= left;
  assign len_w     = last ? left : chunk_w;

  assign size_zero = (q_size[ADDR_BITS-1:0] == '0);
  assign new_limit = POS_W'(q_start[ADDR_BITS-1:0]) + POS_W'(q_size[ADDR_BITS-1:0]);

  // Next state for the item in the input register.
  always_comb begin
    pos_next    = pos;
    limit_next  = limit;
    chunk_next  = chunk;
    active_next = active;
    ce_tot_next = ce_rise ? q_ce : ce_tot;
    ue_tot_next = ue_rise ? q_ue : ue_tot;
    if (can_issue) begin
      pos_next = last ? limit : pos + chunk_w;
      if (last) begin
        active_next = 1'b0;
      end
    end
    if (is_start && !size_zero) begin
      pos_next    = POS_W'(q_start[ADDR_BITS-1:0]);
      limit_next  = new_limit;
      chunk_next  = (q_chunk == '0) ? DEFAULT_CHUNK : q_chunk;
      active_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      limit  <= '0;
      chunk  <= DEFAULT_CHUNK;
      active <= 1'b0;
      ce_tot <= '0;
      ue_tot <= '0;
    end else if (advance) begin
      pos    <= pos_next;
      limit  <= limit_next;
      chunk  <= chunk_next;
      active <= active_next;
      ce_tot <= ce_tot_next;
      ue_tot <= ue_tot_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scrub_valid    <= can_issue;
      scrub_addr     <= can_issue ? 49'(pos) : '0;
      scrub_len      <= can_issue ? len_w[31:0] : '0;
      scrub_busy     <= active_next;
      ce_total       <= ce_tot_next;
      ue_total       <= ue_tot_next;
      log_count      <= head + 8'(n_logged);
      logged_now     <= n_logged;
      start_rejected <= is_start && size_zero;
    end
  end

  // Error log, with its read data lined up with the result register.
  eccps_log #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_log (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .head    (head),
    .rd_kind (entry_kind),
    .rd_addr (entry_addr)
  );

  `ECCPS_ASSERT_NOW(a_pos_le_limit, 1'b1, pos <= limit, "scrub position beyond limit")
  `ECCPS_ASSERT_NOW(a_active_room, active, pos < limit, "scrub active with no bytes left")
  `ECCPS_ASSERT_NOW(a_chunk_nonzero, out_valid && scrub_valid, scrub_len != '0,
                    "issued scrub chunk of zero length")
  `ECCPS_ASSERT_NOW(a_log_only_tick, req.wr0, is_tick && !is_read, "log write on non-tick item")

endmodule
